// File: sv/sbx_pkg.sv
// ----------------------------------------------------------------------------
// sbx_pkg
// Shared types and constants of the sub-box index translator.
// ----------------------------------------------------------------------------
package sbx_pkg;

   localparam int SIZE_W    = 16;
   localparam int AREA_W    = 2 * SIZE_W;
   localparam int TOTAL_W   = 3 * SIZE_W;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BEGIN0  = 3'd0,
      CSR_BEGIN1  = 3'd1,
      CSR_BEGIN2  = 3'd2,
      CSR_SIZE0   = 3'd3,
      CSR_SIZE1   = 3'd4,
      CSR_SIZE2   = 3'd5,
      CSR_EXTENT0 = 3'd6,
      CSR_EXTENT1 = 3'd7
   } csr_idx_type;

   typedef enum logic {
      OP_L2G = 1'b0,
      OP_G2L = 1'b1
   } op_type;

   typedef struct packed {
      logic [SIZE_W-1:0]  begin0;
      logic [SIZE_W-1:0]  begin1;
      logic [SIZE_W-1:0]  begin2;
      logic [SIZE_W-1:0]  sz0;
      logic [SIZE_W-1:0]  sz1;
      logic [SIZE_W-1:0]  sz2;
      logic [SIZE_W-1:0]  ext0;
      logic [SIZE_W-1:0]  ext1;
      logic [AREA_W-1:0]  area01;
      logic [AREA_W-1:0]  stride2;
      logic [TOTAL_W-1:0] total;
   } cfg_type;

endpackage

// File: sv/sbx_if.sv
// ----------------------------------------------------------------------------
// sbx_if
// Request, response and register write channels of the translator.
// ----------------------------------------------------------------------------
interface sbx_req_if #(parameter int INDEX_BITS = 48);
   logic                  valid;
   logic                  ready;
   logic                  opcode;
   logic [INDEX_BITS-1:0] index_in;
   modport source (output valid, opcode, index_in, input ready);
   modport sink (input valid, opcode, index_in, output ready);
endinterface

interface sbx_rsp_if #(parameter int INDEX_BITS = 48);
   logic                  valid;
   logic                  ready;
   logic [INDEX_BITS-1:0] index_out;
   logic                  direction;
   modport source (output valid, index_out, direction, input ready);
   modport sink (input valid, index_out, direction, output ready);
endinterface

interface sbx_csr_if;
   import sbx_pkg::*;
   logic              valid;
   logic              ready;
   csr_idx_type       index;
   logic [SIZE_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: sv/sbx_csr.sv
// ----------------------------------------------------------------------------
// sbx_csr
// Box and grid registers plus derived strides, areas and box volume.
// ----------------------------------------------------------------------------
module sbx_csr #(
   parameter int DIMS = 3
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    wr_vld,
   input  sbx_pkg::csr_idx_type                    wr_idx,
   input  logic [sbx_pkg::SIZE_W-1:0]              wr_data,
   output sbx_pkg::cfg_type                        cfg
);
   import sbx_pkg::*;

   logic [SIZE_W-1:0] begin0_ff, begin1_ff, begin2_ff;
   logic [SIZE_W-1:0] size0_ff, size1_ff, size2_ff;
   logic [SIZE_W-1:0] extent0_ff, extent1_ff;
   logic [SIZE_W-1:0] begin0_in, begin1_in, begin2_in;
   logic [SIZE_W-1:0] size0_in, size1_in, size2_in;
   logic [SIZE_W-1:0] extent0_in, extent1_in;
   cfg_type           cfg_ff, cfg_in;
   logic [SIZE_W-1:0] ext0_eff, ext1_eff, sz1_eff, sz2_eff, b1_eff, b2_eff;

   always_comb begin
      begin0_in  = begin0_ff;
      begin1_in  = begin1_ff;
      begin2_in  = begin2_ff;
      size0_in   = size0_ff;
      size1_in   = size1_ff;
      size2_in   = size2_ff;
      extent0_in = extent0_ff;
      extent1_in = extent1_ff;
      if (wr_vld) begin
         unique case (wr_idx)
            CSR_BEGIN0:  begin0_in  = wr_data;
            CSR_BEGIN1:  begin1_in  = wr_data;
            CSR_BEGIN2:  begin2_in  = wr_data;
            CSR_SIZE0:   size0_in   = wr_data;
            CSR_SIZE1:   size1_in   = wr_data;
            CSR_SIZE2:   size2_in   = wr_data;
            CSR_EXTENT0: extent0_in = wr_data;
            CSR_EXTENT1: extent1_in = wr_data;
            default:     begin0_in  = begin0_ff;
         endcase
      end
   end

   // unused dimensions act as size 1 and begin 0, zero extent acts as 1
   assign ext0_eff = (extent0_ff == '0) ? SIZE_W'(1) : extent0_ff;
   assign ext1_eff = (extent1_ff == '0) ? SIZE_W'(1) : extent1_ff;
   assign sz1_eff  = (DIMS > 1) ? size1_ff : SIZE_W'(1);
   assign sz2_eff  = (DIMS > 2) ? size2_ff : SIZE_W'(1);
   assign b1_eff   = (DIMS > 1) ? begin1_ff : '0;
   assign b2_eff   = (DIMS > 2) ? begin2_ff : '0;

   always_comb begin
      cfg_in         = cfg_ff;
      cfg_in.begin0  = begin0_ff;
      cfg_in.begin1  = b1_eff;
      cfg_in.begin2  = b2_eff;
      cfg_in.sz0     = size0_ff;
      cfg_in.sz1     = sz1_eff;
      cfg_in.sz2     = sz2_eff;
      cfg_in.ext0    = ext0_eff;
      cfg_in.ext1    = ext1_eff;
      cfg_in.area01  = size0_ff * sz1_eff;
      cfg_in.stride2 = ext0_eff * ext1_eff;
      cfg_in.total   = cfg_ff.area01 * cfg_ff.sz2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         begin0_ff  <= '0;
         begin1_ff  <= '0;
         begin2_ff  <= '0;
         size0_ff   <= SIZE_W'(1);
         size1_ff   <= SIZE_W'(1);
         size2_ff   <= SIZE_W'(1);
         extent0_ff <= SIZE_W'(1);
         extent1_ff <= SIZE_W'(1);
         cfg_ff     <= '{begin0: '0, begin1: '0, begin2: '0,
                         sz0: SIZE_W'(1), sz1: SIZE_W'(1), sz2: SIZE_W'(1),
                         ext0: SIZE_W'(1), ext1: SIZE_W'(1),
                         area01: AREA_W'(1), stride2: AREA_W'(1),
                         total: TOTAL_W'(1)};
      end else begin
         begin0_ff  <= begin0_in;
         begin1_ff  <= begin1_in;
         begin2_ff  <= begin2_in;
         size0_ff   <= size0_in;
         size1_ff   <= size1_in;
         size2_ff   <= size2_in;
         extent0_ff <= extent0_in;
         extent1_ff <= extent1_in;
         cfg_ff     <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/sbx_front.sv
// ----------------------------------------------------------------------------
// sbx_front
// Request intake: registers a request and drops out-of-range local indexes.
// ----------------------------------------------------------------------------
module sbx_front #(
   parameter int INDEX_BITS = 48
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_opcode,
   input  logic [INDEX_BITS-1:0]              req_index,
   input  logic [sbx_pkg::TOTAL_W-1:0]        total,
   output logic                               push_vld,
   input  logic                               push_rdy,
   output logic                               push_op,
   output logic [INDEX_BITS-1:0]              push_idx
);
   import sbx_pkg::*;

   logic                  f_vld_ff, f_vld_in;
   logic                  f_keep_ff, f_keep_in;
   logic                  f_op_ff;
   logic [INDEX_BITS-1:0] f_idx_ff;
   logic                  adv;

   assign adv       = !f_vld_ff || !f_keep_ff || push_rdy;
   assign req_ready = adv;
   assign f_vld_in  = adv ? req_valid : f_vld_ff;
   assign f_keep_in = (op_type'(req_opcode) == OP_G2L) || (TOTAL_W'(req_index) < total);

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= f_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_keep_ff <= f_keep_in;
         f_op_ff   <= req_opcode;
         f_idx_ff  <= req_index;
      end
   end

   assign push_vld = f_vld_ff && f_keep_ff;
   assign push_op  = f_op_ff;
   assign push_idx = f_idx_ff;

endmodule

// File: sv/sbx_fifo.sv
// ----------------------------------------------------------------------------
// sbx_fifo
// Short request queue between intake and translation pipeline.
// ----------------------------------------------------------------------------
module sbx_fifo #(
   parameter int WIDTH = 49,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_vld,
   output logic             push_rdy,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_vld,
   input  logic             pop_rdy,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_rdy = (count_ff != CNT_W'(DEPTH));
   assign pop_vld  = (count_ff != '0);
   assign push     = push_vld && push_rdy;
   assign pop      = pop_vld && pop_rdy;
   assign pop_data = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = !push ? wr_ptr_ff :
                      (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
   assign rd_ptr_in = !pop ? rd_ptr_ff :
                      (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
   assign count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count lost a push");
   a_ptr_agree: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree when empty");
`endif

endmodule

// File: sv/sbx_divpipe.sv
// ----------------------------------------------------------------------------
// sbx_divpipe
// Pipelined restoring divider, one quotient bit per stage, with bypass.
// ----------------------------------------------------------------------------
module sbx_divpipe #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 16,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_vld,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic             in_byp,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_vld,
   output logic [NUM_W-1:0] out_quo,
   output logic [NUM_W-1:0] out_coord,
   output logic [TAG_W-1:0] out_tag
);
   logic             st_vld_ff [NUM_W];
   logic [DEN_W-1:0] st_rem_ff  [NUM_W];
   logic [NUM_W-1:0] st_quo_ff  [NUM_W];
   logic [NUM_W-1:0] st_num_ff  [NUM_W];
   logic [DEN_W-1:0] st_den_ff  [NUM_W];
   logic             st_byp_ff  [NUM_W];
   logic [TAG_W-1:0] st_tag_ff  [NUM_W];

   for (genvar g = 0; g < NUM_W; g++) begin : g_stage
      logic             p_vld;
      logic [DEN_W-1:0] p_rem;
      logic [NUM_W-1:0] p_quo;
      logic [NUM_W-1:0] p_num;
      logic [DEN_W-1:0] p_den;
      logic             p_byp;
      logic [TAG_W-1:0] p_tag;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             ge;

      if (g == 0) begin : g_first
         assign p_vld = in_vld;
         assign p_rem = '0;
         assign p_quo = in_num;
         assign p_num = in_num;
         assign p_den = in_den;
         assign p_byp = in_byp;
         assign p_tag = in_tag;
      end else begin : g_next
         assign p_vld = st_vld_ff[g-1];
         assign p_rem = st_rem_ff[g-1];
         assign p_quo = st_quo_ff[g-1];
         assign p_num = st_num_ff[g-1];
         assign p_den = st_den_ff[g-1];
         assign p_byp = st_byp_ff[g-1];
         assign p_tag = st_tag_ff[g-1];
      end

      assign trial = {p_rem, p_quo[NUM_W-1]};
      assign diff  = trial - {1'b0, p_den};
      assign ge    = (trial >= {1'b0, p_den});

      always_ff @(posedge clock) begin
         if (reset) begin
            st_vld_ff[g] <= 1'b0;
         end else if (adv) begin
            st_vld_ff[g] <= p_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_rem_ff[g] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            st_quo_ff[g] <= {p_quo[NUM_W-2:0], ge};
            st_num_ff[g] <= p_num;
            st_den_ff[g] <= p_den;
            st_byp_ff[g] <= p_byp;
            st_tag_ff[g] <= p_tag;
         end
      end
   end

   assign out_vld   = st_vld_ff[NUM_W-1];
   assign out_quo   = st_byp_ff[NUM_W-1] ? '0 : st_quo_ff[NUM_W-1];
   assign out_coord = st_byp_ff[NUM_W-1] ? st_num_ff[NUM_W-1] : NUM_W'(st_rem_ff[NUM_W-1]);
   assign out_tag   = st_tag_ff[NUM_W-1];

endmodule

// File: sv/sbx_back.sv
// ----------------------------------------------------------------------------
// sbx_back
// Translation pipeline: two divider chains, box test, strides and sum.
// ----------------------------------------------------------------------------
module sbx_back #(
   parameter int DIMS       = 3,
   parameter int INDEX_BITS = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sbx_pkg::cfg_type      cfg,
   input  logic                  pop_vld,
   output logic                  pop_rdy,
   input  logic                  pop_op,
   input  logic [INDEX_BITS-1:0] pop_idx,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [INDEX_BITS-1:0] rsp_index,
   output logic                  rsp_dir
);
   import sbx_pkg::*;

   localparam int OPA_W = SIZE_W + 1;
   localparam int P1_W  = OPA_W + SIZE_W;
   localparam int P2_W  = OPA_W + AREA_W;
   localparam int SUM_W = P2_W + 1;

   logic                  adv;
   logic                  d0_vld, d1_vld;
   logic [INDEX_BITS-1:0] d0_quo, d0_coord, d1_quo, d1_coord;
   logic                  d0_tag;
   logic [INDEX_BITS:0]   d1_tag;
   logic                  d0_g2l, d1_g2l;
   logic [INDEX_BITS-1:0] c0, c1, c2;
   logic [INDEX_BITS-1:0] b0x, b1x, b2x;
   logic                  in0, in1, in2;
   logic [INDEX_BITS-1:0] df0, df1, df2;

   logic                  a_vld_ff, a_keep_ff, a_op_ff;
   logic [OPA_W-1:0]      a_base_ff, a_m1a_ff, a_m2a_ff;
   logic [SIZE_W-1:0]     a_m1b_ff;
   logic [AREA_W-1:0]     a_m2b_ff;
   logic                  a_keep_in;
   logic [OPA_W-1:0]      a_base_in, a_m1a_in, a_m2a_in;
   logic [SIZE_W-1:0]     a_m1b_in;
   logic [AREA_W-1:0]     a_m2b_in;

   logic                  b_vld_ff, b_keep_ff, b_op_ff;
   logic [OPA_W-1:0]      b_base_ff;
   logic [P1_W-1:0]       b_p1_ff;
   logic [P2_W-1:0]       b_p2_ff;

   logic                  out_vld_ff, out_vld_in, out_dir_ff;
   logic [INDEX_BITS-1:0] out_idx_ff;
   logic [SUM_W-1:0]      sum;

   assign adv     = !out_vld_ff || rsp_ready;
   assign pop_rdy = adv;
   assign d0_g2l  = (op_type'(pop_op) == OP_G2L);

   sbx_divpipe #(.NUM_W(INDEX_BITS), .DEN_W(SIZE_W), .TAG_W(1)) u_div0 (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_vld    (pop_vld),
      .in_num    (pop_idx),
      .in_den    (d0_g2l ? cfg.ext0 : cfg.sz0),
      .in_byp    (d0_g2l && (DIMS < 2)),
      .in_tag    (pop_op),
      .out_vld   (d0_vld),
      .out_quo   (d0_quo),
      .out_coord (d0_coord),
      .out_tag   (d0_tag)
   );

   assign d1_g2l = (op_type'(d0_tag) == OP_G2L);

   sbx_divpipe #(.NUM_W(INDEX_BITS), .DEN_W(SIZE_W), .TAG_W(INDEX_BITS + 1)) u_div1 (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_vld    (d0_vld),
      .in_num    (d0_quo),
      .in_den    (d1_g2l ? cfg.ext1 : cfg.sz1),
      .in_byp    (d1_g2l && (DIMS < 3)),
      .in_tag    ({d0_tag, d0_coord}),
      .out_vld   (d1_vld),
      .out_quo   (d1_quo),
      .out_coord (d1_coord),
      .out_tag   (d1_tag)
   );

   assign c0  = d1_tag[INDEX_BITS-1:0];
   assign c1  = d1_coord;
   assign c2  = d1_quo;
   assign b0x = INDEX_BITS'(cfg.begin0);
   assign b1x = INDEX_BITS'(cfg.begin1);
   assign b2x = INDEX_BITS'(cfg.begin2);
   assign df0 = c0 - b0x;
   assign df1 = c1 - b1x;
   assign df2 = c2 - b2x;
   assign in0 = (c0 >= b0x) && (df0 < INDEX_BITS'(cfg.sz0));
   assign in1 = (c1 >= b1x) && (df1 < INDEX_BITS'(cfg.sz1));
   assign in2 = (c2 >= b2x) && (df2 < INDEX_BITS'(cfg.sz2));

   always_comb begin
      if (op_type'(d1_tag[INDEX_BITS]) == OP_G2L) begin
         a_keep_in = in0 && in1 && in2;
         a_base_in = {1'b0, df0[SIZE_W-1:0]};
         a_m1a_in  = {1'b0, df1[SIZE_W-1:0]};
         a_m1b_in  = cfg.sz0;
         a_m2a_in  = {1'b0, df2[SIZE_W-1:0]};
         a_m2b_in  = cfg.area01;
      end else begin
         a_keep_in = 1'b1;
         a_base_in = OPA_W'(cfg.begin0) + OPA_W'(c0[SIZE_W-1:0]);
         a_m1a_in  = OPA_W'(cfg.begin1) + OPA_W'(c1[SIZE_W-1:0]);
         a_m1b_in  = cfg.ext0;
         a_m2a_in  = OPA_W'(cfg.begin2) + OPA_W'(c2[SIZE_W-1:0]);
         a_m2b_in  = cfg.stride2;
      end
   end

   assign sum        = SUM_W'(b_base_ff) + SUM_W'(b_p1_ff) + SUM_W'(b_p2_ff);
   assign out_vld_in = adv ? (b_vld_ff && b_keep_ff) : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (adv) begin
            a_vld_ff <= d1_vld;
            b_vld_ff <= a_vld_ff;
         end
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_keep_ff  <= a_keep_in;
         a_op_ff    <= d1_tag[INDEX_BITS];
         a_base_ff  <= a_base_in;
         a_m1a_ff   <= a_m1a_in;
         a_m1b_ff   <= a_m1b_in;
         a_m2a_ff   <= a_m2a_in;
         a_m2b_ff   <= a_m2b_in;
         b_keep_ff  <= a_keep_ff;
         b_op_ff    <= a_op_ff;
         b_base_ff  <= a_base_ff;
         b_p1_ff    <= a_m1a_ff * a_m1b_ff;
         b_p2_ff    <= a_m2a_ff * a_m2b_ff;
         out_dir_ff <= b_op_ff;
         out_idx_ff <= sum[INDEX_BITS-1:0];
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_index = out_idx_ff;
   assign rsp_dir   = out_dir_ff;

endmodule

// File: sv/subbox_index_translator_top.sv
// ----------------------------------------------------------------------------
// subbox_index_translator_top
// Translates indexes between a 3-d sub-box and its enclosing global grid.
// ----------------------------------------------------------------------------
// Accepts one request per cycle while the response side does not stall and
// returns at most one response per request, in request order. Opcode 0 maps a
// box-local index to the row-major grid index; opcode 1 maps a grid index to
// the box-local index and drops points outside the box. Local indexes at or
// beyond the box volume are dropped at intake. Requests pass through two
// chained divider pipelines of INDEX_BITS stages each. The derived box volume
// and strides are registered; the user is to make register writes only while
// no request is in flight, and the block itself does not enforce this.
module subbox_index_translator_top #(
   parameter int DIMS       = 3,
   parameter int INDEX_BITS = 48
) (
   input  logic   clock,
   input  logic   reset,
   sbx_req_if.sink   req,
   sbx_rsp_if.source rsp,
   sbx_csr_if.sink   csr
);
   import sbx_pkg::*;

   cfg_type               cfg;
   logic                  push_vld, push_rdy, push_op;
   logic [INDEX_BITS-1:0] push_idx;
   logic                  pop_vld, pop_rdy;
   logic [INDEX_BITS:0]   pop_data;

   assign csr.ready = 1'b1;

   sbx_csr #(.DIMS(DIMS)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .wr_vld  (csr.valid),
      .wr_idx  (csr.index),
      .wr_data (csr.data),
      .cfg     (cfg)
   );

   sbx_front #(.INDEX_BITS(INDEX_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_ready  (req.ready),
      .req_opcode (req.opcode),
      .req_index  (req.index_in),
      .total      (cfg.total),
      .push_vld   (push_vld),
      .push_rdy   (push_rdy),
      .push_op    (push_op),
      .push_idx   (push_idx)
   );

   sbx_fifo #(.WIDTH(INDEX_BITS + 1), .DEPTH(4)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_vld  (push_vld),
      .push_rdy  (push_rdy),
      .push_data ({push_op, push_idx}),
      .pop_vld   (pop_vld),
      .pop_rdy   (pop_rdy),
      .pop_data  (pop_data)
   );

   sbx_back #(.DIMS(DIMS), .INDEX_BITS(INDEX_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_vld   (pop_vld),
      .pop_rdy   (pop_rdy),
      .pop_op    (pop_data[INDEX_BITS]),
      .pop_idx   (pop_data[INDEX_BITS-1:0]),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .rsp_index (rsp.index_out),
      .rsp_dir   (rsp.direction)
   );

endmodule

// File: tb/sv/subbox_index_translator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subbox_index_translator_top_test
// Checks local/grid index translation of the sub-box translator against a
// built-in arithmetic predictor, over several box and grid settings, with
// random gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module subbox_index_translator_top_test;
   import sbx_pkg::*;

   localparam int IB = 48;
   localparam int LATENCY = 2 * IB + 5;
   localparam int WATCHDOG = 20000;

   typedef struct packed {
      op_type           op;
      logic [IB-1:0]    idx;
   } xlate_req_t;

   typedef struct packed {
      logic [IB-1:0]    idx;
      logic             dir;
   } xlate_rsp_t;

   logic clock = 0;
   logic reset = 1;
   logic req_fire = 0;

   sbx_req_if #(.INDEX_BITS(IB)) req ();
   sbx_rsp_if #(.INDEX_BITS(IB)) rsp ();
   sbx_csr_if csr ();

   subbox_index_translator_top #(.DIMS(3), .INDEX_BITS(IB)) dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   logic [15:0] box_begin [3];
   logic [15:0] box_size [3];
   logic [15:0] grid_ext [2];

   xlate_req_t pending_reqs[$];
   xlate_rsp_t expected_rsps[$];
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int errors = 0;
   int idle_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit translate(input xlate_req_t r, output xlate_rsp_t o);
      logic [63:0] total, rem, acc, stride, e, c, b, s;
      logic [63:0] coord [3];
      total = 64'(box_size[0]) * box_size[1] * box_size[2];
      o.dir = r.op;
      if (r.op == OP_L2G) begin
         if (64'(r.idx) >= total) return 0;
         rem = r.idx;
         coord[0] = rem % box_size[0];
         rem = rem / box_size[0];
         coord[1] = rem % box_size[1];
         coord[2] = rem / box_size[1];
         acc = 0;
         stride = 1;
         for (int d = 0; d < 3; d++) begin
            acc += (64'(box_begin[d]) + coord[d]) * stride;
            if (d < 2) begin
               e = (grid_ext[d] == 0) ? 64'd1 : 64'(grid_ext[d]);
               stride *= e;
            end
         end
         o.idx = acc[IB-1:0];
         return 1;
      end
      rem = r.idx;
      for (int d = 0; d < 2; d++) begin
         e = (grid_ext[d] == 0) ? 64'd1 : 64'(grid_ext[d]);
         coord[d] = rem % e;
         rem = rem / e;
      end
      coord[2] = rem;
      acc = 0;
      stride = 1;
      for (int d = 0; d < 3; d++) begin
         c = coord[d];
         b = box_begin[d];
         s = box_size[d];
         if (c < b || c - b >= s) return 0;
         acc += (c - b) * stride;
         stride *= s;
      end
      o.idx = acc[IB-1:0];
      return 1;
   endfunction

   // request taken at the last rising edge
   always @(posedge clock) begin
      req_fire <= req.valid && req.ready;
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 0;
      end else if (!req.valid || req_fire) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= req_idle_pct) begin
            req.valid <= 1;
            req.opcode <= pending_reqs[0].op;
            req.index_in <= pending_reqs[0].idx;
            void'(pending_reqs.pop_front());
         end else begin
            req.valid <= 0;
         end
      end
      rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // request/response monitor
   always @(posedge clock) begin
      xlate_req_t r;
      xlate_rsp_t o, x;
      int idle_next;
      if (!reset) begin
         idle_next = idle_cycles + 1;
         if (req.valid && req.ready) begin
            idle_next = 0;
            r.op = op_type'(req.opcode);
            r.idx = req.index_in;
            if (translate(r, o)) expected_rsps.push_back(o);
         end
         if (rsp.valid && rsp.ready) begin
            idle_next = 0;
            if (expected_rsps.size() == 0) begin
               $error("unexpected response index_out=%h direction=%b",
                      rsp.index_out, rsp.direction);
               errors++;
            end else begin
               x = expected_rsps.pop_front();
               if (rsp.index_out !== x.idx) begin
                  $error("index_out: expected %h, got %h", x.idx, rsp.index_out);
                  errors++;
               end
               if (rsp.direction !== x.dir) begin
                  $error("direction: expected %b, got %b", x.dir, rsp.direction);
                  errors++;
               end
            end
         end
         if (pending_reqs.size() == 0 && expected_rsps.size() == 0) idle_next = 0;
         idle_cycles <= idle_next;
         if (idle_cycles >= WATCHDOG) begin
            $display("subbox_index_translator_top_test: done, errors");
            $finish;
         end
      end
   end

   task automatic write_reg(input csr_idx_type idx, input logic [15:0] val);
      @(negedge clock);
      csr.valid <= 1;
      csr.index <= idx;
      csr.data <= val;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      @(negedge clock);
      csr.valid <= 0;
      case (idx)
         CSR_BEGIN0, CSR_BEGIN1, CSR_BEGIN2: box_begin[int'(idx)] = val;
         CSR_SIZE0, CSR_SIZE1, CSR_SIZE2: box_size[int'(idx) - 3] = val;
         default: grid_ext[int'(idx) - 6] = val;
      endcase
      repeat (3) @(posedge clock);
   endtask

   task automatic set_box(input int b0, b1, b2, s0, s1, s2, e0, e1);
      write_reg(CSR_BEGIN0, 16'(b0));
      write_reg(CSR_BEGIN1, 16'(b1));
      write_reg(CSR_BEGIN2, 16'(b2));
      write_reg(CSR_SIZE0, 16'(s0));
      write_reg(CSR_SIZE1, 16'(s1));
      write_reg(CSR_SIZE2, 16'(s2));
      write_reg(CSR_EXTENT0, 16'(e0));
      write_reg(CSR_EXTENT1, 16'(e1));
   endtask

   task automatic drain;
      while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic push(input op_type op, input logic [IB-1:0] idx);
      xlate_req_t r;
      r.op = op;
      r.idx = idx;
      pending_reqs.push_back(r);
   endtask

   // mostly in-range random requests for the current box and grid
   task automatic random_burst(input int n);
      logic [63:0] vol, gvol, g;
      int c0, c1, c2;
      vol = 64'(box_size[0]) * box_size[1] * box_size[2];
      for (int i = 0; i < n; i++) begin
         int k;
         k = $urandom_range(9);
         if (k < 4) begin
            g = (vol == 0) ? 64'd0 : {$urandom, $urandom} % vol;
            push(OP_L2G, g[IB-1:0]);
         end else if (k < 8 && box_size[0] != 0 && box_size[1] != 0 && box_size[2] != 0) begin
            c0 = box_begin[0] + $urandom_range(box_size[0] - 1);
            c1 = box_begin[1] + $urandom_range(box_size[1] - 1);
            c2 = box_begin[2] + $urandom_range(box_size[2] - 1);
            if ($urandom_range(3) == 0) c0 = c0 + box_size[0];
            gvol = 64'(c2) * (grid_ext[1] == 0 ? 1 : grid_ext[1]);
            gvol = (gvol + c1) * (grid_ext[0] == 0 ? 1 : grid_ext[0]) + c0;
            push(OP_G2L, gvol[IB-1:0]);
         end else begin
            g = {$urandom, $urandom};
            push(op_type'($urandom_range(1)), g[IB-1:0]);
         end
      end
   endtask

   task automatic set_phase(input int p);
      case (p % 4)
         0: begin req_idle_pct = 0; rsp_stall_pct = 0; end
         1: begin req_idle_pct = 46; rsp_stall_pct = 0; end
         2: begin req_idle_pct = 0; rsp_stall_pct = 46; end
         default: begin req_idle_pct = 38; rsp_stall_pct = 38; end
      endcase
   endtask

   initial begin
      req.valid = 0;
      req.opcode = 0;
      req.index_in = 0;
      rsp.ready = 0;
      csr.valid = 0;
      csr.index = CSR_BEGIN0;
      csr.data = 0;
      box_begin = '{0, 0, 0};
      box_size = '{1, 1, 1};
      grid_ext = '{1, 1};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reset defaults: single point box
      push(OP_L2G, 0);
      push(OP_L2G, 1);
      push(OP_G2L, 0);
      push(OP_G2L, 5);
      drain();

      // directed: small box, grid edges
      set_box(2, 1, 3, 4, 3, 2, 10, 6);
      push(OP_L2G, 0);
      push(OP_L2G, 23);
      push(OP_L2G, 24);
      push(OP_L2G, {IB{1'b1}});
      push(OP_G2L, 3 * 60 + 1 * 10 + 2);
      push(OP_G2L, 4 * 60 + 3 * 10 + 5);
      push(OP_G2L, 4 * 60 + 3 * 10 + 6);
      push(OP_G2L, 0);
      push(OP_G2L, {IB{1'b1}});
      drain();

      // zero size box and zero extents
      set_box(0, 0, 0, 0, 5, 5, 0, 0);
      push(OP_L2G, 0);
      push(OP_G2L, 0);
      push(OP_G2L, 7);
      drain();

      // extremes: near-largest begin, largest size, wrapping global index
      set_box(16'hFFFE, 16'hFFFE, 16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'hFFFF, 16'hFFFF);
      push(OP_L2G, 0);
      push(OP_L2G, {IB{1'b1}});
      push(OP_L2G, 48'h5555_AAAA_5555);
      push(OP_G2L, {IB{1'b1}});
      push(OP_G2L, 48'hFFFE_FFFE_FFFE);
      push(OP_G2L, 0);
      drain();

      // box beyond the grid
      set_box(7, 2, 0, 5, 4, 3, 9, 5);
      push(OP_L2G, 59);
      push(OP_G2L, 8);
      push(OP_G2L, 2 * 9 + 9 + 8);
      drain();

      for (int p = 0; p < 8; p++) begin
         set_phase(p);
         case (p)
            0: set_box(0, 0, 0, 1, 1, 1, 1, 1);
            1: set_box($urandom_range(20), $urandom_range(20), $urandom_range(20),
                       $urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8),
                       $urandom_range(30, 60), $urandom_range(30, 60));
            2: set_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom);
            3: set_box(16'hFFFE, 0, 16'hFFFE, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 1);
            4: set_box($urandom_range(5), $urandom_range(5), $urandom_range(5),
                       $urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16),
                       $urandom_range(0, 20), $urandom_range(0, 20));
            5: set_box(3, 3, 3, $urandom_range(1, 300), $urandom_range(1, 300),
                       $urandom_range(1, 300), 400, 400);
            6: set_box(0, 0, 0, 0, 4, 4, 8, 8);
            default: set_box($urandom_range(100), $urandom_range(100),
                             $urandom_range(100), $urandom_range(1, 100),
                             $urandom_range(1, 100), $urandom_range(1, 100),
                             $urandom_range(1, 200), $urandom_range(1, 200));
         endcase
         random_burst(100);
         drain();
      end

      if (errors == 0) begin
         $display("subbox_index_translator_top_test: done, clean");
      end else begin
         $display("subbox_index_translator_top_test: done, errors");
      end
      $finish;
   end

endmodule
